[src/bidir_raster_pixel_index_macros.svh]
// Assertion macros for the bidirectional raster pixel index block.
// Used by the checker module; relies on clk and rst in the scope of use.
`ifndef BIDIR_RASTER_PIXEL_INDEX_MACROS_SVH
`define BIDIR_RASTER_PIXEL_INDEX_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BRPI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BRPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/brpi_pkg.sv]
// Shared types and constants of the bidirectional raster pixel index block.
// No dependencies; every other file but the assertion macros header imports this package.
package brpi_pkg;

  localparam int MAX_LINE_PIXELS = 4096;
  localparam int MAX_FRAME_LINES = 4096;

  // Counter and length widths follow from the frame limits.
  localparam int COL_W  = $clog2(MAX_LINE_PIXELS);
  localparam int LINE_W = $clog2(MAX_FRAME_LINES);
  localparam int LEN_W  = $clog2(MAX_LINE_PIXELS + 1);
  localparam int FLEN_W = $clog2(MAX_FRAME_LINES + 1);
  localparam int PROD_W = LINE_W + LEN_W;

  // Fixed field widths of the register file and the result.
  localparam int PIX_W      = 13;
  localparam int TURN_W     = 12;
  localparam int CUT_W      = 12;
  localparam int SEND_W     = 13;
  localparam int FRAME_W    = 13;
  localparam int SLINE_W    = 12;
  localparam int SCOL_W     = 12;
  localparam int INDEX_W    = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 13;

  // Register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_PIXELS_PER_LINE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TURN_PIXELS     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CUTOFF_LINES    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SCAN_END_LINE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LINES_PER_FRAME = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_START_LINE      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_START_COLUMN    = 3'd6;

  // Reset values of the registers.
  localparam logic [PIX_W-1:0]   RST_PIXELS_PER_LINE = 13'd512;
  localparam logic [TURN_W-1:0]  RST_TURN_PIXELS     = 12'd0;
  localparam logic [CUT_W-1:0]   RST_CUTOFF_LINES    = 12'd0;
  localparam logic [SEND_W-1:0]  RST_SCAN_END_LINE   = 13'd512;
  localparam logic [FRAME_W-1:0] RST_LINES_PER_FRAME = 13'd512;
  localparam logic [SLINE_W-1:0] RST_START_LINE      = 12'd0;
  localparam logic [SCOL_W-1:0]  RST_START_COLUMN    = 12'd0;

  // Effective scan geometry seen by the datapath.
  typedef struct packed {
    logic [LEN_W-1:0]   plen;       // line length forced into [1, MAX_LINE_PIXELS]
    logic [FLEN_W-1:0]  flen;       // frame length forced into [1, MAX_FRAME_LINES]
    logic [TURN_W-1:0]  turn;
    logic [CUT_W-1:0]   cutoff;
    logic [SEND_W-1:0]  scan_end;
    logic [SLINE_W-1:0] start_line;
    logic [SCOL_W-1:0]  start_col;
    logic [LEN_W-1:0]   width;      // image width, meaningful when turn_ok
    logic               turn_ok;
  } geom_t;

  // Position stage contents handed to the index stage.
  typedef struct packed {
    logic [LINE_W-1:0] row;
    logic [LEN_W-1:0]  offset;
    logic              in_image;
    logic              backward;
  } pos_t;

endpackage

[src/brpi_ifs.sv]
// Valid/ready channel interfaces of the bidirectional raster pixel index block.
// Depends on brpi_pkg for the payload widths.
interface brpi_sample_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface brpi_result_if
  import brpi_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               in_image;
  logic [INDEX_W-1:0] image_index;
  logic               backward_line;

  modport source (output valid, output in_image, output image_index,
                  output backward_line, input ready);
  modport sink (input valid, input in_image, input image_index,
                input backward_line, output ready);
endinterface

interface brpi_cfg_if
  import brpi_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[src/brpi_cfg.sv]
// Register file and effective scan geometry.
// Depends on brpi_pkg and brpi_cfg_if.
module brpi_cfg
  import brpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  brpi_cfg_if.sink    cfg,
  output geom_t       geom
);

  logic [PIX_W-1:0]   pixels_per_line;
  logic [TURN_W-1:0]  turn_pixels;
  logic [CUT_W-1:0]   cutoff_lines;
  logic [SEND_W-1:0]  scan_end_line;
  logic [FRAME_W-1:0] lines_per_frame;
  logic [SLINE_W-1:0] start_line;
  logic [SCOL_W-1:0]  start_column;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_per_line <= RST_PIXELS_PER_LINE;
      turn_pixels     <= RST_TURN_PIXELS;
      cutoff_lines    <= RST_CUTOFF_LINES;
      scan_end_line   <= RST_SCAN_END_LINE;
      lines_per_frame <= RST_LINES_PER_FRAME;
      start_line      <= RST_START_LINE;
      start_column    <= RST_START_COLUMN;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PIXELS_PER_LINE: pixels_per_line <= PIX_W'(cfg.data);
        REG_TURN_PIXELS:     turn_pixels     <= TURN_W'(cfg.data);
        REG_CUTOFF_LINES:    cutoff_lines    <= CUT_W'(cfg.data);
        REG_SCAN_END_LINE:   scan_end_line   <= SEND_W'(cfg.data);
        REG_LINES_PER_FRAME: lines_per_frame <= FRAME_W'(cfg.data);
        REG_START_LINE:      start_line      <= SLINE_W'(cfg.data);
        REG_START_COLUMN:    start_column    <= SCOL_W'(cfg.data);
        default: ;
      endcase
    end
  end

  always_comb begin
    // A zero length counts as one; a length beyond the limit is held at the limit.
    if (pixels_per_line == '0) begin
      geom.plen = LEN_W'(1);
    end else if (32'(pixels_per_line) > MAX_LINE_PIXELS) begin
      geom.plen = LEN_W'(MAX_LINE_PIXELS);
    end else begin
      geom.plen = LEN_W'(pixels_per_line);
    end
    if (lines_per_frame == '0) begin
      geom.flen = FLEN_W'(1);
    end else if (32'(lines_per_frame) > MAX_FRAME_LINES) begin
      geom.flen = FLEN_W'(MAX_FRAME_LINES);
    end else begin
      geom.flen = FLEN_W'(lines_per_frame);
    end
    geom.turn       = turn_pixels;
    geom.cutoff     = cutoff_lines;
    geom.scan_end   = scan_end_line;
    geom.start_line = start_line;
    geom.start_col  = start_column;
    geom.turn_ok    = 32'(turn_pixels) < 32'(geom.plen);
    geom.width      = geom.plen - LEN_W'(turn_pixels);
  end

endmodule

[src/brpi_scan.sv]
// Line and column counters with the position stage register.
// Depends on brpi_pkg and brpi_sample_if.
module brpi_scan
  import brpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  brpi_sample_if.sink sample,
  input  geom_t       geom,
  output pos_t        pos,
  output logic        pos_valid,
  input  logic        pos_take
);

  logic [LINE_W-1:0] line_count;
  logic [COL_W-1:0]  column_count;
  logic [LINE_W-1:0] line_count_next;
  logic [COL_W-1:0]  column_count_next;

  logic [LINE_W-1:0] line_sel;
  logic [COL_W-1:0]  col_sel;
  logic [LINE_W-1:0] line_eff;
  logic [COL_W-1:0]  col_eff;
  logic [LEN_W-1:0]  col_inc;
  logic [FLEN_W-1:0] line_inc;
  logic [LEN_W-1:0]  col_off;
  logic              line_in;
  logic              accept;
  pos_t              pos_next;

  assign sample.ready = !pos_valid || pos_take;
  assign accept       = sample.valid && sample.ready;

  always_comb begin
    line_sel = sample.restart ? LINE_W'(geom.start_line) : line_count;
    col_sel  = sample.restart ? COL_W'(geom.start_col) : column_count;
    // A position at or beyond the current length falls back to zero.
    line_eff = (FLEN_W'(line_sel) >= geom.flen) ? '0 : line_sel;
    col_eff  = (LEN_W'(col_sel) >= geom.plen) ? '0 : col_sel;

    line_in = (32'(line_eff) >= 32'(geom.cutoff)) &&
              (32'(line_eff) < 32'(geom.scan_end)) && geom.turn_ok;
    pos_next.backward = line_eff[0];
    pos_next.in_image = line_in && (32'(col_eff) >= 32'(geom.turn));

    col_off = LEN_W'(col_eff) - LEN_W'(geom.turn);
    if (pos_next.in_image) begin
      pos_next.row    = line_eff - LINE_W'(geom.cutoff);
      pos_next.offset = line_eff[0] ? (geom.width - LEN_W'(1) - col_off) : col_off;
    end else begin
      pos_next.row    = '0;
      pos_next.offset = '0;
    end

    col_inc  = LEN_W'(col_eff) + LEN_W'(1);
    line_inc = FLEN_W'(line_eff) + FLEN_W'(1);
    if (col_inc >= geom.plen) begin
      column_count_next = '0;
      line_count_next   = (line_inc >= geom.flen) ? '0 : LINE_W'(line_inc);
    end else begin
      column_count_next = COL_W'(col_inc);
      line_count_next   = line_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= '0;
      column_count <= '0;
      pos_valid    <= 1'b0;
    end else begin
      if (accept) begin
        line_count   <= line_count_next;
        column_count <= column_count_next;
        pos_valid    <= 1'b1;
      end else if (pos_take) begin
        pos_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos <= pos_next;
    end
  end

endmodule

[src/brpi_index.sv]
// Row base multiply, offset add and the result register.
// Depends on brpi_pkg and brpi_result_if.
module brpi_index
  import brpi_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  pos_t          pos,
  input  logic          pos_valid,
  output logic          pos_take,
  input  logic [LEN_W-1:0] width,
  brpi_result_if.source result
);

  logic               out_valid;
  logic               in_image;
  logic [INDEX_W-1:0] image_index;
  logic               backward_line;
  logic [PROD_W-1:0]  row_base;
  logic [PROD_W:0]    index_sum;

  assign pos_take  = pos_valid && (!out_valid || result.ready);

  // Row base is zero for samples outside the image, since row and offset are.
  assign row_base  = PROD_W'(pos.row) * PROD_W'(width);
  assign index_sum = {1'b0, row_base} + (PROD_W + 1)'(pos.offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pos_take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_take) begin
      in_image      <= pos.in_image;
      image_index   <= INDEX_W'(index_sum);
      backward_line <= pos.backward;
    end
  end

  assign result.valid         = out_valid;
  assign result.in_image      = in_image;
  assign result.image_index   = image_index;
  assign result.backward_line = backward_line;

endmodule

[src/bidir_raster_pixel_index.sv]
// Top level of the bidirectional raster pixel index block.
// Depends on brpi_pkg, the channel interfaces, brpi_cfg, brpi_scan and brpi_index.
//
//   Channel   Modport   Payload                                   Role
//   sample    sink      restart                                   one acquired sample
//   result    source    in_image, image_index, backward_line      pixel address of it
//   cfg       sink      index, data                               register writes
//
// One sample is accepted per clock when the result side keeps up.
// Two register stages (position register, result register) lie between a
// sample transaction and its result: counters and compares before the first,
// one 12 x 13 multiply and an add before the second.
// Reset is synchronous and active high; it clears the counters, both valid
// flags and the register file to its reset values.
// When the result transaction stalls, one further sample is still taken into
// the position register before sample.ready falls.
module bidir_raster_pixel_index
  import brpi_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  brpi_sample_if.sink   sample,
  brpi_result_if.source result,
  brpi_cfg_if.sink      cfg
);

  // Effective geometry derived from the register file. The user must see that registers are
  // only written while the block is idle (not enforced), so items in flight see stable values.
  geom_t geom;

  // Hand-over between the position stage and the index stage.
  pos_t  pos;
  logic  pos_valid;
  logic  pos_take;

  // The register file clamps the line and frame lengths and works out the
  // image width once, so the sample path need not work them out per sample.
  brpi_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .geom (geom)
  );

  // The counters sweep every line of the frame, cutoff and retrace lines
  // included. A restart reloads the start position before the sample is
  // placed, and the position stage records row, offset within the row (mirrored
  // on odd lines) and whether the sample falls inside the image.
  brpi_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .geom      (geom),
    .pos       (pos),
    .pos_valid (pos_valid),
    .pos_take  (pos_take)
  );

  // The index stage forms row times width plus offset, kept to 24 bits, and
  // holds the finished result until the downstream side takes it.
  brpi_index u_index (
    .clk       (clk),
    .rst       (rst),
    .pos       (pos),
    .pos_valid (pos_valid),
    .pos_take  (pos_take),
    .width     (geom.width),
    .result    (result)
  );

endmodule

[src/brpi_checker.sv]
// Port-level checks of the bidirectional raster pixel index block.
// Depends on brpi_pkg and the assertion macros header; bound to the top level below.
`include "bidir_raster_pixel_index_macros.svh"

module brpi_checker
  import brpi_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic               result_in_image,
  input logic [INDEX_W-1:0] result_image_index,
  input logic               result_backward_line
);

  // A sample outside the image always carries index zero.
  `BRPI_ASSERT_NOW(a_index_zero_outside, result_valid && !result_in_image, result_image_index == '0, "image index not zero outside the image")

  // A stalled result stays offered and unchanged.
  `BRPI_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(result_in_image) && $stable(result_image_index) && $stable(result_backward_line), "stalled result changed")

  // Only one sample can be buffered behind a stalled result.
  `BRPI_ASSERT_NEXT(a_one_buffered, result_valid && !result_ready && sample_valid && sample_ready, result_ready || !sample_ready, "sample taken beyond the position stage capacity")

endmodule

bind bidir_raster_pixel_index brpi_checker u_brpi_checker (
  .clk                  (clk),
  .rst                  (rst),
  .sample_valid         (sample.valid),
  .sample_ready         (sample.ready),
  .result_valid         (result.valid),
  .result_ready         (result.ready),
  .result_in_image      (result.in_image),
  .result_image_index   (result.image_index),
  .result_backward_line (result.backward_line)
);
